// ===== hw/rtl/sxn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxn_pkg
// Shared constants and types of the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sxn_pkg;

   // default coordinate width, signed Q4.12
   localparam int COORD_WIDTH_DEFAULT = 16;

   // parallel threshold register, unsigned Q0.24
   localparam int EPS_WIDTH = 24;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 24'd16777;

   // result status codes
   localparam int STATUS_WIDTH = 2;
   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_CROSS    = 2'd1,
      STATUS_PARALLEL = 2'd2
   } status_type;

endpackage

// ===== hw/rtl/sxn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxn_front
// Four stage front end: differences, products, determinant and numerators,
// then classification and the scaled numerators for the crossing point.
// ----------------------------------------------------------------------------
module sxn_front
   import sxn_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   localparam int DW = COORD_WIDTH + 1,
   localparam int PW = 2 * COORD_WIDTH + 2,
   localparam int NW = 2 * COORD_WIDTH + 3,
   localparam int MW = 3 * COORD_WIDTH + 4,
   localparam int SW = STATUS_WIDTH + 2 * COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] a_start_x,
   input  logic signed [COORD_WIDTH-1:0] a_start_y,
   input  logic signed [COORD_WIDTH-1:0] a_end_x,
   input  logic signed [COORD_WIDTH-1:0] a_end_y,
   input  logic signed [COORD_WIDTH-1:0] b_start_x,
   input  logic signed [COORD_WIDTH-1:0] b_start_y,
   input  logic signed [COORD_WIDTH-1:0] b_end_x,
   input  logic signed [COORD_WIDTH-1:0] b_end_y,
   input  logic        [EPS_WIDTH-1:0]   det_epsilon,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [MW-1:0]          out_num_x,
   output logic signed [MW-1:0]          out_num_y,
   output logic signed [NW-1:0]          out_det,
   output logic        [SW-1:0]          out_side
);

   localparam int EW = (NW > EPS_WIDTH) ? NW : EPS_WIDTH;

   // stage enables, a stage loads when empty or when its successor loads
   logic en1, en2, en3, en4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // stage 1: edge and offset vectors
   logic signed [DW-1:0] dxa_in, dya_in, dxb_in, dyb_in, ox_in, oy_in;
   logic signed [DW-1:0] dxa_ff, dya_ff, dxb_ff, dyb_ff, ox_ff, oy_ff;
   logic signed [COORD_WIDTH-1:0] xa0_1_ff, ya0_1_ff;

   assign dxa_in = DW'(a_end_x) - DW'(a_start_x);
   assign dya_in = DW'(a_end_y) - DW'(a_start_y);
   assign dxb_in = DW'(b_end_x) - DW'(b_start_x);
   assign dyb_in = DW'(b_end_y) - DW'(b_start_y);
   assign ox_in  = DW'(a_start_x) - DW'(b_start_x);
   assign oy_in  = DW'(a_start_y) - DW'(b_start_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= in_valid;
      end
      if (en1) begin
         dxa_ff   <= dxa_in;
         dya_ff   <= dya_in;
         dxb_ff   <= dxb_in;
         dyb_ff   <= dyb_in;
         ox_ff    <= ox_in;
         oy_ff    <= oy_in;
         xa0_1_ff <= a_start_x;
         ya0_1_ff <= a_start_y;
      end
   end

   // stage 2: six cross products
   logic signed [PW-1:0] p1_in, p2_in, p3_in, p4_in, p5_in, p6_in;
   logic signed [PW-1:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff;
   logic signed [DW-1:0] dxa_2_ff, dya_2_ff;
   logic signed [COORD_WIDTH-1:0] xa0_2_ff, ya0_2_ff;

   assign p1_in = PW'(dxa_ff) * PW'(dyb_ff);
   assign p2_in = PW'(dya_ff) * PW'(dxb_ff);
   assign p3_in = PW'(oy_ff) * PW'(dxb_ff);
   assign p4_in = PW'(ox_ff) * PW'(dyb_ff);
   assign p5_in = PW'(oy_ff) * PW'(dxa_ff);
   assign p6_in = PW'(ox_ff) * PW'(dya_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         p3_ff    <= p3_in;
         p4_ff    <= p4_in;
         p5_ff    <= p5_in;
         p6_ff    <= p6_in;
         dxa_2_ff <= dxa_ff;
         dya_2_ff <= dya_ff;
         xa0_2_ff <= xa0_1_ff;
         ya0_2_ff <= ya0_1_ff;
      end
   end

   // stage 3: determinant and both numerators
   logic signed [NW-1:0] d_in, na_in, nb_in;
   logic signed [NW-1:0] d_ff, na_ff, nb_ff;
   logic signed [DW-1:0] dxa_3_ff, dya_3_ff;
   logic signed [COORD_WIDTH-1:0] xa0_3_ff, ya0_3_ff;

   assign d_in  = NW'(p1_ff) - NW'(p2_ff);
   assign na_in = NW'(p3_ff) - NW'(p4_ff);
   assign nb_in = NW'(p5_ff) - NW'(p6_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         d_ff     <= d_in;
         na_ff    <= na_in;
         nb_ff    <= nb_in;
         dxa_3_ff <= dxa_2_ff;
         dya_3_ff <= dya_2_ff;
         xa0_3_ff <= xa0_2_ff;
         ya0_3_ff <= ya0_2_ff;
      end
   end

   // stage 4: parallel test, strict ratio tests, scaled numerators
   logic [NW-1:0] abs_d;
   logic          is_parallel, is_zero, inside_a, inside_b;
   status_type    status_in, status_ff;
   logic signed [MW-1:0] px_in, py_in, px_ff, py_ff;
   logic signed [NW-1:0] d_4_ff;
   logic signed [COORD_WIDTH-1:0] xa0_4_ff, ya0_4_ff;

   assign abs_d       = d_ff[NW-1] ? $unsigned(-d_ff) : $unsigned(d_ff);
   assign is_parallel = EW'(abs_d) < EW'(det_epsilon);
   assign is_zero     = (d_ff == '0);

   // ratio n/d strictly inside (0,1), sign aware
   assign inside_a = d_ff[NW-1] ? (na_ff[NW-1] && (d_ff < na_ff))
                                : (!na_ff[NW-1] && (na_ff != '0) && (na_ff < d_ff));
   assign inside_b = d_ff[NW-1] ? (nb_ff[NW-1] && (d_ff < nb_ff))
                                : (!nb_ff[NW-1] && (nb_ff != '0) && (nb_ff < d_ff));

   always_comb begin
      if (is_parallel) begin
         status_in = STATUS_PARALLEL;
      end else if (!is_zero && inside_a && inside_b) begin
         status_in = STATUS_CROSS;
      end else begin
         status_in = STATUS_NONE;
      end
   end

   assign px_in = MW'(na_ff) * MW'(dxa_3_ff);
   assign py_in = MW'(na_ff) * MW'(dya_3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3_ff;
      end
      if (en4) begin
         status_ff <= status_in;
         px_ff     <= px_in;
         py_ff     <= py_in;
         d_4_ff    <= d_ff;
         xa0_4_ff  <= xa0_3_ff;
         ya0_4_ff  <= ya0_3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_num_x = px_ff;
   assign out_num_y = py_ff;
   assign out_det   = d_4_ff;
   // side band, low bits up: status, start x, start y
   assign out_side  = {ya0_4_ff, xa0_4_ff, status_ff};

`ifndef ASSERT_OFF
   // a crossing needs a determinant that is not zero
   a_cross_nonzero: assert property (@(posedge clock) disable iff (reset)
      v3_ff && en4 && (status_in == STATUS_CROSS) |=> (d_4_ff != '0))
      else $error("crossing classified with zero determinant");
`endif

endmodule

// ===== hw/rtl/sxn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxn_div
// Pipelined restoring divider, two lanes sharing one divisor: one entry
// stage takes magnitudes, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module sxn_div
   import sxn_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   localparam int NW = 2 * COORD_WIDTH + 3,
   localparam int MW = 3 * COORD_WIDTH + 4,
   localparam int SW = STATUS_WIDTH + 2 * COORD_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [MW-1:0]   in_num_x,
   input  logic signed [MW-1:0]   in_num_y,
   input  logic signed [NW-1:0]   in_det,
   input  logic        [SW-1:0]   in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [COORD_WIDTH-1:0] out_quot_x,
   output logic [COORD_WIDTH-1:0] out_quot_y,
   output logic                   out_neg_x,
   output logic                   out_neg_y,
   output logic [SW-1:0]          out_side
);

   localparam int W = COORD_WIDTH;

   logic                v_ff    [0:W];
   logic                en      [0:W];
   logic [MW-1:0]       rx_ff   [0:W];
   logic [MW-1:0]       ry_ff   [0:W];
   logic [NW-1:0]       dabs_ff [0:W];
   logic [W-1:0]        qx_ff   [0:W];
   logic [W-1:0]        qy_ff   [0:W];
   logic                negx_ff [0:W];
   logic                negy_ff [0:W];
   logic [SW-1:0]       side_ff [0:W];

   // enable chain from the output back to the entry
   assign en[W] = !v_ff[W] || out_ready;
   for (genvar k = 0; k < W; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end
   assign in_ready = en[0];

   // entry stage: magnitudes and result signs
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= in_valid;
      end
      if (en[0]) begin
         rx_ff[0]   <= in_num_x[MW-1] ? $unsigned(-in_num_x) : $unsigned(in_num_x);
         ry_ff[0]   <= in_num_y[MW-1] ? $unsigned(-in_num_y) : $unsigned(in_num_y);
         dabs_ff[0] <= in_det[NW-1] ? $unsigned(-in_det) : $unsigned(in_det);
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         negx_ff[0] <= in_num_x[MW-1] != in_det[NW-1];
         negy_ff[0] <= in_num_y[MW-1] != in_det[NW-1];
         side_ff[0] <= in_side;
      end
   end

   // quotient stages, most significant bit first
   for (genvar k = 1; k <= W; k++) begin : g_step
      localparam int SH = W - k;
      logic [MW-1:0] dsh;
      logic          ge_x, ge_y;
      logic [W-1:0]  qbit;

      assign dsh  = MW'(dabs_ff[k-1]) << SH;
      assign ge_x = rx_ff[k-1] >= dsh;
      assign ge_y = ry_ff[k-1] >= dsh;
      assign qbit = W'(1) << SH;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (en[k]) begin
            rx_ff[k]   <= ge_x ? (rx_ff[k-1] - dsh) : rx_ff[k-1];
            ry_ff[k]   <= ge_y ? (ry_ff[k-1] - dsh) : ry_ff[k-1];
            qx_ff[k]   <= ge_x ? (qx_ff[k-1] | qbit) : qx_ff[k-1];
            qy_ff[k]   <= ge_y ? (qy_ff[k-1] | qbit) : qy_ff[k-1];
            dabs_ff[k] <= dabs_ff[k-1];
            negx_ff[k] <= negx_ff[k-1];
            negy_ff[k] <= negy_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid  = v_ff[W];
   assign out_quot_x = qx_ff[W];
   assign out_quot_y = qy_ff[W];
   assign out_neg_x  = negx_ff[W];
   assign out_neg_y  = negy_ff[W];
   assign out_side   = side_ff[W];

`ifndef ASSERT_OFF
   // the pipeline is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !v_ff[W])
      else $error("divider output valid right after reset");
`endif

endmodule

// ===== hw/rtl/segment_intersection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection
// Fixed point 2D segment crossing test; the crossing point's offset from the
// start of segment a is rounded toward zero.
// throughput: one segment pair per cycle while rsp_tready is held, set by the fully pipelined
//   multiply stages and the one bit per stage divider
// reset: synchronous, clears all stage valid bits and loads det_epsilon
//   with 16777 (about 0.001 in Q0.24)
module segment_intersection
   import sxn_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   localparam int IW = ((8 * COORD_WIDTH + 7) / 8) * 8,
   localparam int RW = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                    clock,
   input  logic                    reset,
   // fields from bit 0: a_start_x, a_start_y, a_end_x, a_end_y,
   // b_start_x, b_start_y, b_end_x, b_end_y
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [IW-1:0]           req_tdata,
   // fields from bit 0: cross_x, cross_y
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RW-1:0]           rsp_tdata,
   // fields from bit 0: status
   output logic [STATUS_WIDTH-1:0] rsp_tuser,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [EPS_WIDTH-1:0]    csr_data
);

   localparam int W  = COORD_WIDTH;
   localparam int NW = 2 * W + 3;
   localparam int MW = 3 * W + 4;
   localparam int SW = STATUS_WIDTH + 2 * W;

   // threshold register
   logic [EPS_WIDTH-1:0] eps_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_valid) begin
         eps_ff <= csr_data;
      end
   end

   // front end
   logic                 f_valid, f_ready;
   logic signed [MW-1:0] f_num_x, f_num_y;
   logic signed [NW-1:0] f_det;
   logic [SW-1:0]        f_side;

   sxn_front #(.COORD_WIDTH(W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .a_start_x   ($signed(req_tdata[0*W +: W])),
      .a_start_y   ($signed(req_tdata[1*W +: W])),
      .a_end_x     ($signed(req_tdata[2*W +: W])),
      .a_end_y     ($signed(req_tdata[3*W +: W])),
      .b_start_x   ($signed(req_tdata[4*W +: W])),
      .b_start_y   ($signed(req_tdata[5*W +: W])),
      .b_end_x     ($signed(req_tdata[6*W +: W])),
      .b_end_y     ($signed(req_tdata[7*W +: W])),
      .det_epsilon (eps_ff),
      .out_valid   (f_valid),
      .out_ready   (f_ready),
      .out_num_x   (f_num_x),
      .out_num_y   (f_num_y),
      .out_det     (f_det),
      .out_side    (f_side)
   );

   // divider
   logic          q_valid, q_ready, q_neg_x, q_neg_y;
   logic [W-1:0]  q_x, q_y;
   logic [SW-1:0] q_side;

   sxn_div #(.COORD_WIDTH(W)) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (f_valid),
      .in_ready   (f_ready),
      .in_num_x   (f_num_x),
      .in_num_y   (f_num_y),
      .in_det     (f_det),
      .in_side    (f_side),
      .out_valid  (q_valid),
      .out_ready  (q_ready),
      .out_quot_x (q_x),
      .out_quot_y (q_y),
      .out_neg_x  (q_neg_x),
      .out_neg_y  (q_neg_y),
      .out_side   (q_side)
   );

   // output stage: signed quotient plus start point
   status_type             st;
   logic signed [W-1:0]    xa0, ya0;
   logic signed [W:0]      qsx, qsy, sum_x, sum_y;
   logic                   en_out;
   logic                   rsp_valid_ff;
   status_type             status_ff;
   logic signed [W-1:0]    cx_in, cy_in, cx_ff, cy_ff;

   assign st    = status_type'(q_side[STATUS_WIDTH-1:0]);
   assign xa0   = $signed(q_side[STATUS_WIDTH +: W]);
   assign ya0   = $signed(q_side[STATUS_WIDTH + W +: W]);
   assign qsx   = q_neg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
   assign qsy   = q_neg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
   assign sum_x = (W + 1)'(xa0) + qsx;
   assign sum_y = (W + 1)'(ya0) + qsy;
   assign cx_in = (st == STATUS_CROSS) ? sum_x[W-1:0] : '0;
   assign cy_in = (st == STATUS_CROSS) ? sum_y[W-1:0] : '0;

   assign en_out  = !rsp_valid_ff || rsp_tready;
   assign q_ready = en_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= q_valid;
      end
      if (en_out) begin
         status_ff <= st;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RW'({cy_ff, cx_ff});
   assign rsp_tuser  = status_ff;

`ifndef ASSERT_OFF
   // point fields are zero unless the segments cross
   a_zero_point: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_CROSS) |-> (cx_ff == '0) && (cy_ff == '0))
      else $error("nonzero point without crossing");
   // no result right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
   // a result that is taken is replaced only by what the divider offers
   a_refill: assert property (@(posedge clock) disable iff (reset)
      en_out && !q_valid |=> !rsp_tvalid)
      else $error("result appeared without divider transfer");
`endif

endmodule
